### src/lnorm_pkg.sv
// Shared types and constants for the line ending normalizer.
// Holds the input and result beat structs, character codes and register indexes.
// No dependencies.
package lnorm_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_SP = 8'h20;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_UNIX_ENDINGS = 2'd0;
    localparam logic [1:0] REG_TRIM_TRAILING = 2'd1;
    localparam logic [1:0] REG_KEEP_ZERO = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       spilled;
        logic       last_of_run;
    } out_beat_t;

endpackage

### src/lnorm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read data holds its value in cycles without a read. No dependencies.
module lnorm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/line_ending_normalizer.sv
// Top level of the line ending normalizer: APB registers, item sequencer and hold ring.
// Depends on lnorm_pkg and lnorm_ram.
//
//   channel  | ports                          | beat moves when
//   input    | s_valid, s_ready, s_data       | s_valid && s_ready
//   result   | m_valid, m_ready, m_data       | m_valid && m_ready
//   config   | psel, penable, pwrite, paddr.. | psel && penable && pwrite (pready high)
//
// A byte that releases nothing held passes through ST_D0 or ST_FIN; a dos line end adds ST_D1.
// Each held byte released or spilled adds ST_RD and ST_POP: a hold RAM read, then the output.
// One item is in work at a time; s_ready is high only while the sequencer is idle.
// A stalled m_ready holds the sequencer in its emit state; results wait in one output register.
// Reset clears control registers, counts and pointers; data registers and the hold RAM are not cleared.
module line_ending_normalizer
    import lnorm_pkg::*;
#(
    parameter int HOLD_DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HOLD_DEPTH - 1);
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(HOLD_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_POP  = 6'b000100,
        ST_D0   = 6'b001000,
        ST_D1   = 6'b010000,
        ST_FIN  = 6'b100000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    logic          unix_reg, trim_reg, keepz_reg;
    logic          prev_cr_reg, prev_cr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] pops_reg, pops_next;
    logic          spill_reg, spill_next;
    logic          d0_vld_reg, d0_vld_next;
    logic [7:0]    d0_byte_reg, d0_byte_next;
    logic          d1_vld_reg, d1_vld_next;
    logic          clr_reg, clr_next;
    logic          wr_reg, wr_next;
    logic [7:0]    wbyte_reg, wbyte_next;
    logic          m_valid_reg, m_valid_next;
    out_beat_t     m_data_reg, m_data_next;

    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic          in_fire, out_space, pop_fire, fin;
    logic          ram_re, ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_rdata;

    logic          b_drop, b_lf, b_cr, b_hold, b_eos;
    logic [7:0]    b_val;
    logic [CW-1:0] p_pops;
    logic          p_spill, p_d0v, p_d1v, p_clr, p_wr;
    logic [7:0]    p_d0b;

    logic [AW-1:0] h1;
    logic [CW-1:0] c1;
    logic [CW:0]   wsum;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_UNIX_ENDINGS:  prdata[0] = unix_reg;
            REG_TRIM_TRAILING: prdata[0] = trim_reg;
            REG_KEEP_ZERO:     prdata[0] = keepz_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unix_reg  <= 1'b1;
            trim_reg  <= 1'b0;
            keepz_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_UNIX_ENDINGS:  unix_reg <= pwdata[0];
                REG_TRIM_TRAILING: trim_reg <= pwdata[0];
                REG_KEEP_ZERO:     keepz_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_space = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        b_val  = s_data.in_byte;
        b_eos  = s_data.end_of_stream;
        b_cr   = (b_val == CHAR_CR);
        b_lf   = (b_val == CHAR_LF);
        b_drop = (b_val == CHAR_NUL) && !keepz_reg;
        b_hold = trim_reg ? (b_val <= CHAR_SP) : b_cr;

        p_pops  = '0;
        p_spill = 1'b0;
        p_d0v   = 1'b0;
        p_d0b   = b_val;
        p_d1v   = 1'b0;
        p_clr   = 1'b0;
        p_wr    = 1'b0;

        if (b_drop) begin
            if (b_eos && !trim_reg) begin
                p_pops = count_reg;
            end
        end else if (b_lf) begin
            p_clr = 1'b1;
            if (!trim_reg) begin
                p_pops = (prev_cr_reg && count_reg != '0) ? count_reg - CW'(1) : count_reg;
            end
            p_d0v = 1'b1;
            if (unix_reg) begin
                p_d0b = CHAR_LF;
            end else begin
                p_d0b = CHAR_CR;
                p_d1v = 1'b1;
            end
        end else if (b_hold) begin
            if (trim_reg) begin
                if (count_reg == DEPTH_C) begin
                    p_pops  = CW'(1);
                    p_spill = 1'b1;
                end
                p_wr = !b_eos;
            end else begin
                p_pops = count_reg;
                p_clr  = 1'b1;
                if (b_eos) begin
                    p_d0v = 1'b1;
                end else begin
                    p_wr = 1'b1;
                end
            end
        end else begin
            p_pops = count_reg;
            p_clr  = 1'b1;
            p_d0v  = 1'b1;
        end
        if (b_eos) begin
            p_clr = 1'b1;
        end
    end

    always_comb begin
        state_next   = state_reg;
        pops_next    = pops_reg;
        spill_next   = spill_reg;
        d0_vld_next  = d0_vld_reg;
        d0_byte_next = d0_byte_reg;
        d1_vld_next  = d1_vld_reg;
        clr_next     = clr_reg;
        wr_next      = wr_reg;
        wbyte_next   = wbyte_reg;
        prev_cr_next = prev_cr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_re       = 1'b0;
        pop_fire     = 1'b0;
        fin          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    pops_next    = p_pops;
                    spill_next   = p_spill;
                    d0_vld_next  = p_d0v;
                    d0_byte_next = p_d0b;
                    d1_vld_next  = p_d1v;
                    clr_next     = p_clr;
                    wr_next      = p_wr;
                    wbyte_next   = b_val;
                    prev_cr_next = b_cr && !b_eos;
                    if (p_pops != '0) begin
                        state_next = ST_RD;
                    end else if (p_d0v) begin
                        state_next = ST_D0;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_RD: begin
                ram_re     = 1'b1;
                state_next = ST_POP;
            end
            ST_POP: begin
                if (out_space) begin
                    pop_fire     = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_byte: ram_rdata, spilled: spill_reg,
                                     last_of_run: (pops_reg == CW'(1)) && !d0_vld_reg};
                    pops_next    = pops_reg - CW'(1);
                    if (pops_reg != CW'(1)) begin
                        state_next = ST_RD;
                    end else if (d0_vld_reg) begin
                        state_next = ST_D0;
                    end else begin
                        fin        = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_D0: begin
                if (out_space) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_byte: d0_byte_reg, spilled: 1'b0,
                                     last_of_run: !d1_vld_reg};
                    if (d1_vld_reg) begin
                        state_next = ST_D1;
                    end else begin
                        fin        = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_D1: begin
                if (out_space) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_byte: CHAR_LF, spilled: 1'b0, last_of_run: 1'b1};
                    fin          = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FIN: begin
                fin        = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        h1 = head_reg;
        c1 = count_reg;
        if (pop_fire) begin
            h1 = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
            c1 = count_reg - CW'(1);
        end
        if (fin && clr_reg) begin
            h1 = '0;
            c1 = '0;
        end
        wsum = (CW + 1)'(h1) + (CW + 1)'(c1);
        if (wsum >= DEPTH_W) begin
            wsum = wsum - DEPTH_W;
        end
        ram_waddr = wsum[AW-1:0];
        ram_we    = fin && wr_reg;
        if (ram_we) begin
            c1 = c1 + CW'(1);
        end
        if (cfg_wr && cfg_idx == REG_TRIM_TRAILING && pwdata[0] != trim_reg) begin
            h1 = '0;
            c1 = '0;
        end
        head_next  = h1;
        count_next = c1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            prev_cr_reg <= 1'b0;
            count_reg   <= '0;
            head_reg    <= '0;
            pops_reg    <= '0;
            spill_reg   <= 1'b0;
            d0_vld_reg  <= 1'b0;
            d1_vld_reg  <= 1'b0;
            clr_reg     <= 1'b0;
            wr_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prev_cr_reg <= prev_cr_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            pops_reg    <= pops_next;
            spill_reg   <= spill_next;
            d0_vld_reg  <= d0_vld_next;
            d1_vld_reg  <= d1_vld_next;
            clr_reg     <= clr_next;
            wr_reg      <= wr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d0_byte_reg <= d0_byte_next;
        wbyte_reg   <= wbyte_next;
        m_data_reg  <= m_data_next;
    end

    lnorm_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wbyte_reg),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

endmodule

### dv/line_ending_normalizer_tb.sv
// Self-checking testbench for line_ending_normalizer: a directed run and then random text
// streams over several register settings, checked against an in-bench line ending model.
// Depends on lnorm_pkg and the line_ending_normalizer RTL.
module line_ending_normalizer_tb;
    import lnorm_pkg::*;

    localparam int HOLD_DEPTH = 32;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 34;
    localparam int MAX_PRINTED = 40;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_beat_t             m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Model of the block: register copies, CR tracking and the whitespace hold ring.
    logic       lf_only = 1'b1;
    logic       trim_ws = 1'b0;
    logic       keep_nul = 1'b0;
    logic       last_was_cr = 1'b0;
    logic [7:0] ring_q [HOLD_DEPTH];
    int         ring_fill = 0;
    int         ring_rd = 0;

    in_beat_t  byte_stream[$];
    out_beat_t step_beats[$];
    out_beat_t predicted_beats[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    int counted_items = 0;

    line_ending_normalizer #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 aclk = ~aclk;

    function automatic void emit_byte(input logic [7:0] b, input logic sp);
        out_beat_t beat;
        beat.out_byte = b;
        beat.spilled = sp;
        beat.last_of_run = 1'b0;
        step_beats.push_back(beat);
    endfunction

    function automatic void spill_oldest(input logic sp);
        emit_byte(ring_q[ring_rd], sp);
        ring_rd = (ring_rd + 1) % HOLD_DEPTH;
        ring_fill = ring_fill - 1;
    endfunction

    function automatic void flush_ring();
        while (ring_fill > 0) spill_oldest(1'b0);
        ring_rd = 0;
    endfunction

    function automatic void ring_push(input logic [7:0] b);
        if (ring_fill >= HOLD_DEPTH) spill_oldest(1'b1);
        ring_q[(ring_rd + ring_fill) % HOLD_DEPTH] = b;
        ring_fill = ring_fill + 1;
    endfunction

    function automatic void normalize_byte(input in_beat_t item);
        logic [7:0] b;
        out_beat_t  tail;
        b = item.in_byte;
        if (b == CHAR_NUL && !keep_nul) begin
            // A dropped zero byte still breaks a CR LF pair below.
        end else if (b == CHAR_LF) begin
            if (trim_ws) begin
                ring_fill = 0;
                ring_rd = 0;
            end else begin
                if (last_was_cr && ring_fill > 0) ring_fill = ring_fill - 1;
                flush_ring();
            end
            if (!lf_only) emit_byte(CHAR_CR, 1'b0);
            emit_byte(CHAR_LF, 1'b0);
        end else if (trim_ws ? (b <= CHAR_SP) : (b == CHAR_CR)) begin
            if (!trim_ws) flush_ring();
            ring_push(b);
        end else begin
            flush_ring();
            emit_byte(b, 1'b0);
        end
        last_was_cr = (b == CHAR_CR);
        if (item.end_of_stream) begin
            if (!trim_ws) flush_ring();
            ring_fill = 0;
            ring_rd = 0;
            last_was_cr = 1'b0;
        end
        if (step_beats.size() != 0) begin
            tail = step_beats.pop_back();
            tail.last_of_run = 1'b1;
            step_beats.push_back(tail);
        end
        while (step_beats.size() != 0) predicted_beats.push_back(step_beats.pop_front());
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("t=%0t %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {31'($urandom()), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_UNIX_ENDINGS: lf_only = value;
            REG_TRIM_TRAILING: begin
                if (value != trim_ws) begin
                    ring_fill = 0;
                    ring_rd = 0;
                end
                trim_ws = value;
            end
            REG_KEEP_ZERO: keep_nul = value;
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic unix_v, input logic trim_v, input logic keep_v);
        write_reg(REG_UNIX_ENDINGS, unix_v);
        write_reg(REG_TRIM_TRAILING, trim_v);
        write_reg(REG_KEEP_ZERO, keep_v);
    endtask

    task automatic queue_item(input logic [7:0] b, input logic eos);
        in_beat_t item;
        item.in_byte = b;
        item.end_of_stream = eos;
        byte_stream.push_back(item);
        if (b != CHAR_NUL || keep_nul) counted_items++;
    endtask

    // One text line: a word, a whitespace run (sometimes long enough to overflow the
    // hold ring), some noise, one of several line endings and now and then a stream end.
    task automatic queue_random_line();
        int n;
        n = $urandom_range(0, 6);
        repeat (n) queue_item(8'($urandom_range(8'h21, 8'hFF)), 1'b0);
        n = ($urandom_range(7) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 3);
        repeat (n) queue_item(8'($urandom_range(0, 32)), 1'b0);
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) queue_item(8'($urandom()), $urandom_range(9) == 0);
        end
        case ($urandom_range(9))
            0, 1, 2, 3: queue_item(CHAR_LF, 1'b0);
            4, 5, 6: begin
                queue_item(CHAR_CR, 1'b0);
                queue_item(CHAR_LF, 1'b0);
            end
            7: queue_item(CHAR_CR, 1'b0);
            8: begin
                queue_item(CHAR_CR, 1'b0);
                queue_item(CHAR_NUL, 1'b0);
                queue_item(CHAR_LF, 1'b0);
            end
            default: ;
        endcase
        if ($urandom_range(7) == 0) queue_item(8'($urandom()), 1'b1);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (byte_stream.size() != 0 || s_valid || predicted_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) normalize_byte(s_data);
            if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= byte_stream.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_OFF_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_beats.size() == 0) begin
                report_mismatch("unexpected result beat", int'(m_data), 0);
            end else begin
                want = predicted_beats.pop_front();
                if (m_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", int'(m_data.out_byte), int'(want.out_byte));
                if (m_data.spilled !== want.spilled)
                    report_mismatch("spilled", int'(m_data.spilled), int'(want.spilled));
                if (m_data.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", int'(m_data.last_of_run),
                                    int'(want.last_of_run));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (psel && penable && pwrite)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int p;
        int target;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 58;
        write_settings(1'b1, 1'b0, 1'b0);
        write_reg(REG_UNUSED, 1'b1);
        queue_item(8'h41, 1'b0);
        queue_item(CHAR_CR, 1'b0);
        queue_item(CHAR_LF, 1'b0);
        queue_item(CHAR_CR, 1'b0);
        queue_item(CHAR_CR, 1'b0);
        queue_item(8'h42, 1'b0);
        queue_item(CHAR_CR, 1'b0);
        queue_item(CHAR_NUL, 1'b0);
        queue_item(CHAR_LF, 1'b0);
        queue_item(CHAR_LF, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(CHAR_CR, 1'b1);
        wait_drained();

        write_reg(REG_UNIX_ENDINGS, 1'b0);
        write_reg(REG_KEEP_ZERO, 1'b1);
        queue_item(8'h7F, 1'b0);
        queue_item(CHAR_LF, 1'b0);
        queue_item(CHAR_CR, 1'b0);
        queue_item(CHAR_LF, 1'b0);
        queue_item(CHAR_NUL, 1'b0);
        queue_item(CHAR_CR, 1'b0);
        wait_drained();

        // Turning trim on here throws away the CR that is still pending.
        write_reg(REG_TRIM_TRAILING, 1'b1);
        queue_item(CHAR_SP, 1'b0);
        queue_item(8'h09, 1'b0);
        queue_item(CHAR_NUL, 1'b0);
        queue_item(8'h43, 1'b0);
        queue_item(CHAR_SP, 1'b0);
        queue_item(CHAR_LF, 1'b0);
        queue_item(CHAR_CR, 1'b1);
        queue_item(8'h09, 1'b0);
        wait_drained();

        for (p = 0; p < 8; p++) begin
            if (p < 3) begin
                send_idle_pct = 15;
                recv_idle_pct = 58;
            end else if (p < 6) begin
                send_idle_pct = 58;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_settings(p[0], p[1], p[2]);
            target = counted_items + ITEMS_PER_PHASE;
            while (counted_items < target) queue_random_line();
            if (p == 6) hold_requests++;
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
src/lnorm_pkg.sv
src/lnorm_ram.sv
src/line_ending_normalizer.sv
dv/line_ending_normalizer_tb.sv
